[rtl/core/fbba_pkg.sv]
// ----------------------------------------------------------------------------
// fbba_pkg: shared types and constants of the free-block bitmap allocator
// Holds the map geometry, request codes, the command format passed from the
// front end to the back end, and helpers for the reset image and the search.
// ----------------------------------------------------------------------------
package fbba_pkg;

	localparam int MAP_BYTES       = 512;
	localparam int RESERVED_BLOCKS = 10;

	localparam int INDEX_W    = 12;
	localparam int INDEX_SPAN = 1 << INDEX_W;
	localparam int MAP_BLOCKS = MAP_BYTES * 8;
	localparam int LIVE_BLOCKS = (MAP_BLOCKS < INDEX_SPAN) ? MAP_BLOCKS : INDEX_SPAN;

	localparam int WORD_W = 64;
	localparam int COL_W  = $clog2(WORD_W);
	localparam int ROW_W  = INDEX_W - COL_W;
	localparam int ROWS   = 1 << ROW_W;

	localparam int MODE_W    = 2;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 16;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef enum logic [MODE_W-1:0] {
		MODE_FIND   = 2'd0,
		MODE_MARK   = 2'd1,
		MODE_UNMARK = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		CMD_FIND,
		CMD_WRITE,
		CMD_REPORT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [INDEX_W-1:0] index;
		logic               set_free;
		logic               index_error;
	} cmd_t;

	typedef enum logic {
		BK_IDLE,
		BK_EXEC
	} back_state_t;

	function automatic logic [WORD_W-1:0] reset_word(input logic [ROW_W-1:0] row);
		logic [WORD_W-1:0] w;
		int                b;
		for (int k = 0; k < WORD_W; k++) begin
			b    = int'(row) * WORD_W + k;
			w[k] = (b >= RESERVED_BLOCKS) && (b < LIVE_BLOCKS);
		end
		return w;
	endfunction

	function automatic logic [ROWS-1:0] reset_summary();
		logic [ROWS-1:0] s;
		for (int r = 0; r < ROWS; r++) begin
			s[r] = |reset_word(ROW_W'(r));
		end
		return s;
	endfunction

	localparam logic [ROWS-1:0] RESET_SUMMARY = reset_summary();

	function automatic logic [COL_W-1:0] lowest_set64(input logic [WORD_W-1:0] w);
		logic [COL_W-1:0] r;
		r = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (w[i]) begin
				r = COL_W'(i);
			end
		end
		return r;
	endfunction

	function automatic logic [ROW_W-1:0] lowest_row(input logic [ROWS-1:0] s);
		logic [ROW_W-1:0] r;
		r = '0;
		for (int i = ROWS - 1; i >= 0; i--) begin
			if (s[i]) begin
				r = ROW_W'(i);
			end
		end
		return r;
	endfunction

endpackage

[rtl/core/fbba_front.sv]
// ----------------------------------------------------------------------------
// fbba_front: request intake and classification
// Takes requests from the input stream, checks the index against the map and
// holds one classified command until the command queue takes it.
// ----------------------------------------------------------------------------
module fbba_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [fbba_pkg::IN_DATA_W-1:0] in_data,
	output logic                           push_valid,
	input  logic                           push_ready,
	output fbba_pkg::cmd_t                 push_cmd
);
	import fbba_pkg::*;

	logic                cmd_valid_q;
	cmd_t                cmd_q;
	cmd_t                cmd_d;
	logic [MODE_W-1:0]   mode;
	logic [INDEX_W-1:0]  index;
	logic                out_of_map;

	assign mode       = in_data[MODE_W-1:0];
	assign index      = in_data[MODE_W +: INDEX_W];
	assign out_of_map = (32'(index) >= LIVE_BLOCKS);

	always_comb begin
		cmd_d.kind        = CMD_REPORT;
		cmd_d.index       = '0;
		cmd_d.set_free    = 1'b0;
		cmd_d.index_error = 1'b0;
		unique case (mode_t'(mode)) inside
			MODE_FIND: begin
				cmd_d.kind = CMD_FIND;
			end
			MODE_MARK, MODE_UNMARK: begin
				cmd_d.index       = index;
				cmd_d.set_free    = (mode_t'(mode) == MODE_UNMARK);
				cmd_d.index_error = out_of_map;
				cmd_d.kind        = out_of_map ? CMD_REPORT : CMD_WRITE;
			end
			default: begin
				cmd_d.kind = CMD_REPORT;
			end
		endcase
	end

	assign in_ready   = !cmd_valid_q || push_ready;
	assign push_valid = cmd_valid_q;
	assign push_cmd   = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			cmd_valid_q <= 1'b1;
		end else if (push_ready) begin
			cmd_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q <= cmd_d;
		end
	end

endmodule

[rtl/core/fbba_queue.sv]
// ----------------------------------------------------------------------------
// fbba_queue: command queue
// A short first-in first-out buffer of classified commands between the front
// end and the back end.
// ----------------------------------------------------------------------------
module fbba_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  fbba_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop,
	output fbba_pkg::cmd_t pop_cmd
);
	import fbba_pkg::*;

	cmd_t               entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != Q_CNT_W'(Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

[rtl/core/fbba_back.sv]
// ----------------------------------------------------------------------------
// fbba_back: bitmap store and command execution
// Keeps the map as 64-bit words in a memory with a valid bit and a nonzero
// summary bit per word, runs find, read-modify-write and report commands, and
// drives the result register.
// ----------------------------------------------------------------------------
module fbba_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	input  fbba_pkg::cmd_t                  cmd,
	output logic                            cmd_pop,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [fbba_pkg::OUT_DATA_W-1:0] out_data
);
	import fbba_pkg::*;

	logic [WORD_W-1:0]  mem [ROWS];

	back_state_t        state_q;
	back_state_t        next_state;
	logic [ROWS-1:0]    row_valid_q;
	logic [ROWS-1:0]    summary_q;
	logic [ROW_W-1:0]   row_s1;
	cmd_t               cmd_s1;
	logic [WORD_W-1:0]  rd_data_s1;
	logic               rd_valid_s1;

	logic               out_valid_q;
	logic               out_found_q;
	logic [INDEX_W-1:0] out_number_q;
	logic               out_error_q;

	logic               out_free;
	logic               pop;
	logic               map_empty;
	logic [ROW_W-1:0]   rd_row;
	logic [WORD_W-1:0]  word_eff;
	logic [WORD_W-1:0]  new_word;
	logic [COL_W-1:0]   col;

	logic               out_load;
	logic               out_found_d;
	logic [INDEX_W-1:0] out_number_d;
	logic               out_error_d;
	logic               wr_en;

	assign out_free  = !out_valid_q || out_ready;
	assign pop       = (state_q == BK_IDLE) && cmd_valid && out_free;
	assign cmd_pop   = pop;
	assign map_empty = (summary_q == '0);
	assign rd_row    = (cmd.kind == CMD_FIND) ? lowest_row(summary_q) : cmd.index[INDEX_W-1 -: ROW_W];
	assign word_eff  = rd_valid_s1 ? rd_data_s1 : reset_word(row_s1);
	assign col       = lowest_set64(word_eff);

	always_comb begin
		new_word = word_eff;
		new_word[cmd_s1.index[COL_W-1:0]] = cmd_s1.set_free;
	end

	always_comb begin
		next_state = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (pop && ((cmd.kind == CMD_WRITE) || ((cmd.kind == CMD_FIND) && !map_empty))) begin
					next_state = BK_EXEC;
				end
			end
			BK_EXEC: begin
				next_state = BK_IDLE;
			end
			default: begin
				next_state = BK_IDLE;
			end
		endcase
	end

	always_comb begin
		out_load     = 1'b0;
		out_found_d  = 1'b0;
		out_number_d = '0;
		out_error_d  = 1'b0;
		wr_en        = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (pop) begin
					case (cmd.kind)
						CMD_FIND: begin
							out_load = map_empty;
						end
						CMD_REPORT: begin
							out_load     = 1'b1;
							out_number_d = cmd.index;
							out_error_d  = cmd.index_error;
						end
						default: begin
							out_load = 1'b0;
						end
					endcase
				end
			end
			BK_EXEC: begin
				case (cmd_s1.kind)
					CMD_FIND: begin
						out_load     = 1'b1;
						out_found_d  = 1'b1;
						out_number_d = {row_s1, col};
					end
					CMD_WRITE: begin
						out_load     = 1'b1;
						out_number_d = cmd_s1.index;
						wr_en        = 1'b1;
					end
					default: begin
						out_load = 1'b0;
					end
				endcase
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			row_valid_q <= '0;
			summary_q   <= RESET_SUMMARY;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= next_state;
			if (wr_en) begin
				row_valid_q[row_s1] <= 1'b1;
				summary_q[row_s1]   <= |new_word;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			row_s1      <= rd_row;
			cmd_s1      <= cmd;
			rd_data_s1  <= mem[rd_row];
			rd_valid_s1 <= row_valid_q[rd_row];
		end
		if (wr_en) begin
			mem[row_s1] <= new_word;
		end
		if (out_load) begin
			out_found_q  <= out_found_d;
			out_number_q <= out_number_d;
			out_error_q  <= out_error_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {{(OUT_DATA_W - INDEX_W - 2){1'b0}}, out_error_q, out_number_q, out_found_q};

endmodule

[rtl/core/free_block_bitmap_allocator.sv]
// ----------------------------------------------------------------------------
// free_block_bitmap_allocator: free-block bitmap allocator, top level
// Finds the lowest free block, marks blocks used or free, one result per
// request.
//
//   Channel   Direction  Signals                      Contents (low bit first)
//   s_axis    in         tvalid, tready, tdata[15:0]  mode[1:0], block_index[13:2]
//   m_axis    out        tvalid, tready, tdata[15:0]  found[0], block_number[12:1],
//                                                     index_error[13]
//
// The back end takes one command at a time: it answers from its idle state when the
// map is not read (unused mode, index error, find on a full map), and goes through its
// execute state for a find, mark or unmark, which uses the registered read of the
// 64-bit map word memory. A request passes the front end command register and the queue.
// Reset restores the initial map at once through per-word valid bits.
// A stalled output holds the back end; three more requests fit before the input stalls.
// ----------------------------------------------------------------------------
module free_block_bitmap_allocator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [fbba_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // mode, block_index
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [fbba_pkg::OUT_DATA_W-1:0] m_axis_tdata   // found, block_number, index_error
);
	import fbba_pkg::*;

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop;
	cmd_t pop_cmd;

	fbba_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_data    (s_axis_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	fbba_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_cmd    (pop_cmd)
	);

	fbba_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (pop_valid),
		.cmd       (pop_cmd),
		.cmd_pop   (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

[rtl/core/fbba_checker.sv]
// ----------------------------------------------------------------------------
// fbba_port_checks: port-level checks of the free-block bitmap allocator
// Watches the request and result streams of the top level and is bound to it.
// ----------------------------------------------------------------------------
module fbba_port_checks (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic [fbba_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [fbba_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import fbba_pkg::*;

	logic       in_xfer;
	logic       req_xfer;
	logic       rsp_xfer;
	logic [3:0] inflight_q;

	assign in_xfer  = s_axis_tvalid && s_axis_tready && (s_axis_tdata[MODE_W-1:0] != '0);
	assign req_xfer = s_axis_tvalid && s_axis_tready;
	assign rsp_xfer = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (req_xfer && !rsp_xfer) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (rsp_xfer && !req_xfer) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("Result changed or dropped while stalled.");

	a_found_err_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[INDEX_W + 1]))
		else $error("A result reports both a found block and an index error.");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[OUT_DATA_W-1:INDEX_W + 2] == '0))
		else $error("Result padding bits are not zero.");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && (inflight_q == '0) |=> !m_axis_tvalid)
		else $error("A result appeared one cycle after a request with nothing in flight.");

endmodule

bind free_block_bitmap_allocator fbba_port_checks u_fbba_checker (.*);
